@@ hw/rtl/rlb_pkg.sv @@
// Shared types and constants for the rev light bar color and fill block.
// Holds the controller state type, the command and status structs and the
// color and scaling constants; depends on nothing.
package rlb_pkg;

  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned GEAR_W      = 5;
  localparam int unsigned PM_W        = 10;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned LIT_W       = 5;
  localparam int unsigned PROD_W      = 26;  // rpm * 1000 fits in 26 bits
  localparam int unsigned IN_DATA_W   = 40;  // 37 field bits padded to bytes
  localparam int unsigned OUT_DATA_W  = 48;  // 44 field bits padded to bytes
  localparam int unsigned STEP_CNT_W  = 4;

  localparam logic [PM_W-1:0]       FULL_SCALE   = 10'd1000;
  localparam logic [PM_W-1:0]       GREEN_LIMIT  = 10'd600;
  localparam logic [PM_W-1:0]       YELLOW_LIMIT = 10'd750;
  localparam logic signed [11:0]    RED_BASE     = 12'sd875;
  localparam logic [COLOR_W-1:0]    GREEN_BASE   = 8'd25;
  localparam logic [COLOR_W-1:0]    COLOR_FULL   = 8'd255;
  localparam logic [COLOR_W-1:0]    COLOR_HALF   = 8'd128;
  localparam logic [COLOR_W-1:0]    COLOR_OFF    = 8'd0;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP    = 4'd9;

  // Reciprocal constants: 230/600 scaled by 2^20, 21/1000 and 18/1000 by 2^24.
  localparam logic [18:0] GREEN_RECIP = 19'd401971;
  localparam logic [18:0] SIDE_RECIP  = 19'd352338;
  localparam logic [18:0] EDGE_RECIP  = 19'd302004;

  localparam logic MODE_STATUS    = 1'b0;
  localparam logic MODE_TELEMETRY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } rlb_state_t;

  typedef struct packed {
    logic store_max;
    logic load_item;
    logic mul;
    logic div_step;
    logic finish;
  } rlb_cmd_t;

  typedef struct packed {
    logic max_zero;
    logic div_done;
    logic out_busy;
  } rlb_status_t;

endpackage

@@ hw/rtl/rev_light_bar_color_and_fill.sv @@
// Top level of the rev light bar color and fill block.
// Instantiates rlb_ctrl and rlb_datapath; uses rlb_pkg.
//
// The block turns engine speed into a shift-light bar setting. Each input
// beat on the slave stream carries a kind flag in s_axis_tuser: a status
// beat (flag 0) stores the car's maximum rpm and gives no result; a
// telemetry beat (flag 1) gives one result beat on the master stream with
// the color of the lit LEDs, the lit counts per side strip and per edge
// half, and the engine speed in thousandths of the maximum, clamped to
// 1000. A telemetry beat that arrives while the stored maximum is zero is
// dropped without a result.
//
// Timing: a status beat stores the maximum in the idle state. A telemetry
// beat goes through these steps in order from acceptance to the result on
// m_axis_tvalid: the multiply step forms rpm*1000, the restoring divider
// yields one quotient bit per cycle, and the finish step picks the color
// and registers the result. The next item is accepted in the cycle after
// the result is registered, so no new telemetry item is taken before then.
//
// Reset (rst, synchronous, active high) clears the stored maximum to zero
// and empties the output register. If the receiver stalls, the result waits
// in the output register while the next item is taken and worked on; that
// item then holds in its final step until the waiting result is taken.
module rev_light_bar_color_and_fill (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // max_engine_speed[15:0], engine_speed[31:16], gear_selected[36:32]
  input  logic [rlb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // mode[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], side_lit[28:24], edge_lit[33:29],
  // per_mille[43:34]
  output logic [rlb_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import rlb_pkg::*;

  rlb_cmd_t                 cmd;
  rlb_status_t              status;
  logic                     in_beat;
  logic [COLOR_W-1:0]       red;
  logic [COLOR_W-1:0]       green;
  logic [COLOR_W-1:0]       blue;
  logic [LIT_W-1:0]         side_lit;
  logic [LIT_W-1:0]         edge_lit;
  logic [PM_W-1:0]          per_mille;

  // The controller only acts on a beat while it reports ready, so the
  // valid it sees is already qualified by the handshake.
  assign in_beat = s_axis_tvalid;

  rlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_beat),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rlb_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .max_engine_speed (s_axis_tdata[15:0]),
    .engine_speed     (s_axis_tdata[31:16]),
    .gear_selected    ($signed(s_axis_tdata[36:32])),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .side_lit         (side_lit),
    .edge_lit         (edge_lit),
    .per_mille        (per_mille)
  );

  // Pack the result fields from the lowest bit up, zero padded to bytes.
  assign m_axis_tdata = {4'b0000, per_mille, edge_lit, side_lit, blue, green, red};

endmodule

@@ hw/rtl/rlb_ctrl.sv @@
// Controller state machine for the rev light bar block.
// Sequences store, multiply, divide and finish steps; uses rlb_pkg.
module rlb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  rlb_pkg::rlb_status_t status,
  output rlb_pkg::rlb_cmd_t    cmd
);
  import rlb_pkg::*;

  rlb_state_t state;
  rlb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_STATUS) begin
            cmd.store_max = 1'b1;
          end else if (!status.max_zero) begin
            cmd.load_item = 1'b1;
            state_next    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/rlb_datapath.sv @@
// Datapath for the rev light bar block: stored maximum, restoring divider,
// color selection, lit counts and the output register; uses rlb_pkg.
module rlb_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  rlb_pkg::rlb_cmd_t                  cmd,
  output rlb_pkg::rlb_status_t               status,
  input  logic [rlb_pkg::SPEED_W-1:0]        max_engine_speed,
  input  logic [rlb_pkg::SPEED_W-1:0]        engine_speed,
  input  logic signed [rlb_pkg::GEAR_W-1:0]  gear_selected,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rlb_pkg::COLOR_W-1:0]        red,
  output logic [rlb_pkg::COLOR_W-1:0]        green,
  output logic [rlb_pkg::COLOR_W-1:0]        blue,
  output logic [rlb_pkg::LIT_W-1:0]          side_lit,
  output logic [rlb_pkg::LIT_W-1:0]          edge_lit,
  output logic [rlb_pkg::PM_W-1:0]           per_mille
);
  import rlb_pkg::*;

  logic [SPEED_W-1:0]       stored_max_speed;
  logic [SPEED_W-1:0]       rpm;
  logic signed [GEAR_W-1:0] gear;
  logic                     sat;
  logic [SPEED_W-1:0]       rem;
  logic [PM_W-1:0]          num_low;
  logic [PM_W-1:0]          quo;
  logic [STEP_CNT_W-1:0]    step_cnt;

  logic [PROD_W-1:0]        prod;
  logic [SPEED_W:0]         trial;
  logic                     trial_ge;
  logic [PM_W-1:0]          p;
  logic [28:0]              green_prod;
  logic [28:0]              side_prod;
  logic [28:0]              edge_prod;
  logic signed [11:0]       red_limit;
  logic signed [11:0]       p_s;
  logic [COLOR_W-1:0]       red_next;
  logic [COLOR_W-1:0]       green_next;
  logic [COLOR_W-1:0]       blue_next;

  assign status.max_zero = (stored_max_speed == '0);
  assign status.div_done = (step_cnt == LAST_STEP);
  assign status.out_busy = out_valid && !out_ready;

  // Stored maximum and item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_max_speed <= '0;
    end else if (cmd.store_max) begin
      stored_max_speed <= max_engine_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rpm  <= engine_speed;
      gear <= gear_selected;
      sat  <= (engine_speed >= stored_max_speed);
    end
  end

  // Restoring division of rpm*1000 by the stored maximum. When rpm is below
  // the maximum the quotient is below 1000, so ten quotient bits suffice and
  // the upper numerator bits start out below the divisor.
  assign prod     = PROD_W'(rpm) * PROD_W'(FULL_SCALE);
  assign trial    = {rem, num_low[PM_W-1]};
  assign trial_ge = (trial >= {1'b0, stored_max_speed});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem      <= prod[PROD_W-1:PM_W];
      num_low  <= prod[PM_W-1:0];
      quo      <= '0;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= trial_ge ? SPEED_W'(trial - {1'b0, stored_max_speed})
                           : trial[SPEED_W-1:0];
      num_low  <= {num_low[PM_W-2:0], 1'b0};
      quo      <= {quo[PM_W-2:0], trial_ge};
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // Color and lit counts from the clamped per-mille value.
  assign p          = sat ? FULL_SCALE : quo;
  assign green_prod = 29'(p) * 29'(GREEN_RECIP);
  assign side_prod  = 29'(p) * 29'(SIDE_RECIP);
  assign edge_prod  = 29'(p) * 29'(EDGE_RECIP);
  assign red_limit  = RED_BASE - {{5{gear[GEAR_W-1]}}, gear, 2'b00};
  assign p_s        = $signed({2'b00, p});

  always_comb begin
    if (p <= GREEN_LIMIT) begin
      red_next   = COLOR_OFF;
      green_next = GREEN_BASE + green_prod[27:20];
      blue_next  = COLOR_OFF;
    end else if (p <= YELLOW_LIMIT) begin
      red_next   = COLOR_FULL;
      green_next = COLOR_FULL;
      blue_next  = COLOR_OFF;
    end else if (p_s <= red_limit) begin
      red_next   = COLOR_FULL;
      green_next = COLOR_OFF;
      blue_next  = COLOR_OFF;
    end else begin
      red_next   = COLOR_HALF;
      green_next = COLOR_OFF;
      blue_next  = COLOR_FULL;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      red       <= red_next;
      green     <= green_next;
      blue      <= blue_next;
      side_lit  <= side_prod[28:24];
      edge_lit  <= edge_prod[28:24];
      per_mille <= p;
    end
  end

endmodule

@@ sim/rlb_checker.sv @@
// Scoreboard for the rev light bar block: watches both stream channels,
// predicts each result beat and compares it field by field.
// Depends on rlb_pkg for the stream widths and the beat kind codes.
module rlb_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_valid,
  input  logic                           s_ready,
  input  logic [rlb_pkg::IN_DATA_W-1:0]  s_data,
  input  logic                           s_user,
  input  logic                           m_valid,
  input  logic                           m_ready,
  input  logic [rlb_pkg::OUT_DATA_W-1:0] m_data,
  output int                             fail_count,
  output int                             outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import rlb_pkg::*;

  typedef struct {
    int unsigned red;
    int unsigned green;
    int unsigned blue;
    int unsigned side_lit;
    int unsigned edge_lit;
    int unsigned per_mille;
  } bar_setting_t;

  bar_setting_t      bar_settings_q[$];
  logic [15:0]       known_max_rpm;
  int                mismatches;

  // Works out the bar setting for one telemetry beat against the known maximum.
  function automatic bar_setting_t shift_light_for(logic [15:0] rpm, logic [4:0] gear_raw,
                                                   logic [15:0] max_rpm);
    bar_setting_t s;
    int unsigned  fill;
    int           red_top;
    fill = (32'(rpm) * 32'd1000) / 32'(max_rpm);
    if (fill > 1000) fill = 1000;
    red_top = 875 - 4 * int'($signed(gear_raw));
    if (fill <= 600) begin
      s.red = 0;   s.green = 25 + (230 * fill) / 600; s.blue = 0;
    end else if (fill <= 750) begin
      s.red = 255; s.green = 255; s.blue = 0;
    end else if (int'(fill) <= red_top) begin
      s.red = 255; s.green = 0;   s.blue = 0;
    end else begin
      s.red = 128; s.green = 0;   s.blue = 255;
    end
    s.side_lit  = (21 * fill) / 1000;
    s.edge_lit  = (18 * fill) / 1000;
    s.per_mille = fill;
    return s;
  endfunction

  function automatic int field_differs(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
  end

  always @(posedge clk) begin : watch
    bar_setting_t want;
    if (rst) begin
      known_max_rpm = '0;
      bar_settings_q.delete();
    end else begin
      // Results are retired before new beats are queued, so a stray result
      // can never be matched against an item taken on the same edge.
      if (m_valid && m_ready) begin
        if (bar_settings_q.size() == 0) begin
          $error("result beat arrived with no telemetry beat waiting");
          mismatches++;
        end else begin
          want = bar_settings_q.pop_front();
          mismatches += field_differs("red",       want.red,       m_data[7:0]);
          mismatches += field_differs("green",     want.green,     m_data[15:8]);
          mismatches += field_differs("blue",      want.blue,      m_data[23:16]);
          mismatches += field_differs("side_lit",  want.side_lit,  m_data[28:24]);
          mismatches += field_differs("edge_lit",  want.edge_lit,  m_data[33:29]);
          mismatches += field_differs("per_mille", want.per_mille, m_data[43:34]);
          mismatches += field_differs("tdata padding", 0, m_data[OUT_DATA_W-1:44]);
        end
      end
      if (s_valid && s_ready) begin
        if (s_user == MODE_STATUS) begin
          known_max_rpm = s_data[15:0];
        end else if (known_max_rpm != 0) begin
          bar_settings_q.push_back(shift_light_for(s_data[31:16], s_data[36:32],
                                                   known_max_rpm));
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= bar_settings_q.size();
  end

endmodule

@@ sim/rev_light_bar_color_and_fill_tb.sv @@
// Testbench top for the rev light bar color and fill block: drives status and
// telemetry beats, stalls the result stream and gives the verdict.
// Depends on rlb_pkg, rev_light_bar_color_and_fill and rlb_checker.
module rev_light_bar_color_and_fill_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import rlb_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  // Cycles with no beat taken on either side before the run is declared hung.
  // The worst honest quiet spell is a sender gap plus a full telemetry pass
  // plus a receiver stall.
  localparam int QUIET_LIMIT  = 1000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // max_engine_speed[15:0], engine_speed[31:16], gear_selected[36:32]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // mode[0]
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // red[7:0], green[15:8], blue[23:16], side_lit[28:24], edge_lit[33:29],
  // per_mille[43:34]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int          fail_count;
  int          outstanding;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  logic [15:0] cur_max = '0;   // the maximum the block should hold, used to aim rpm values
  rx_style_t   rx_style = RX_OPEN;
  int          rx_left = 0;
  logic [4:0]  rx_cycle = '0;

  rev_light_bar_color_and_fill u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rlb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_data      (s_axis_tdata),
    .s_user      (s_axis_tuser),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_data      (m_axis_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The receiver switches between styles of back-pressure after random spells:
  // always ready, a coin toss per cycle, ready with a chance of one in four,
  // and a fixed pattern that is ready whenever rx_cycle[4:3] is 2'b11.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (rx_left == 0) begin
        rx_style <= rx_style_t'($urandom_range(0, 3));
        rx_left  <= $urandom_range(20, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_style)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (rx_cycle[4:3] == 2'b11);
      endcase
    end
  end

  // Hang detection: the run ends as failed once nothing has moved on either
  // stream for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rev_light_bar_color_and_fill_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one beat and waits for it to be taken. The sender works in
  // bursts; at the end of a burst valid drops for a random gap, so valid is
  // never lowered and raised in the same step.
  task automatic send_beat(input logic kind, input logic [15:0] max_rpm,
                           input logic [15:0] rpm, input logic [4:0] gear);
    if (burst_left == 0) begin
      if (s_axis_tvalid) begin
        s_axis_tvalid <= 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(5, 30)) @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, gear, rpm, max_rpm};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  // Status beat: the unused speed and gear fields carry random junk.
  task automatic send_status(input logic [15:0] max_rpm);
    cur_max = max_rpm;
    send_beat(MODE_STATUS, max_rpm, 16'($urandom), 5'($urandom));
  endtask

  // Telemetry beat: the unused maximum field carries random junk.
  task automatic send_telemetry(input logic [15:0] rpm, input logic [4:0] gear);
    send_beat(MODE_TELEMETRY, 16'($urandom), rpm, gear);
  endtask

  // Holds the sender until every predicted result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One random beat. Most are telemetry aimed at a spread of fractions of the
  // current maximum, with a share near the color thresholds; the rest are
  // fully random speeds and occasional new maxima, zero among them.
  task automatic send_random_item(output bit counted);
    int unsigned pick;
    int unsigned scaled;
    logic [4:0]  gear;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      case ($urandom_range(0, 9))
        0:       send_status(16'd0);
        1, 2:    send_status(16'($urandom_range(1, 20)));
        3:       send_status(16'd1000);
        4:       send_status(16'hFFFF);
        default: send_status(16'($urandom));
      endcase
      counted = 1'b1;
    end else begin
      // Half the gears stay in the road range from reverse to eighth, the
      // rest use every 5-bit code.
      if ($urandom_range(0, 1) == 1) gear = 5'($urandom_range(0, 31));
      else gear = 5'(int'($urandom_range(0, 9)) - 1);
      if (pick < 70) begin
        scaled = (32'(cur_max) * $urandom_range(0, 1100)) / 1000;
      end else if (pick < 80) begin
        scaled = (32'(cur_max) * $urandom_range(595, 945)) / 1000 + $urandom_range(0, 2);
      end else begin
        scaled = $urandom_range(0, 65535);
      end
      if (scaled > 65535) scaled = 65535;
      counted = (cur_max != 0);
      send_telemetry(16'(scaled), gear);
    end
  endtask

  initial begin : stimulus
    int  useful;
    bit  counted;
    useful = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Telemetry before any maximum is known, and after a zero maximum, is
    // dropped without a result.
    send_telemetry(16'd5000, 5'd3);
    send_status(16'd0);
    send_telemetry(16'hFFFF, 5'd1);

    // Widest maximum: full speed and standstill.
    send_status(16'hFFFF);
    send_telemetry(16'hFFFF, 5'd0);
    send_telemetry(16'd0, 5'd0);

    // Smallest maximum: any nonzero speed saturates at full scale.
    send_status(16'd1);
    send_telemetry(16'd0, 5'd2);
    send_telemetry(16'd1, 5'd2);
    send_telemetry(16'hFFFF, 5'd2);

    // A maximum of 1000 makes rpm equal the fraction, so each color boundary
    // can be hit exactly, with the red limit moved by the lowest and highest
    // gear codes as well as neutral, reverse and eighth.
    send_status(16'd1000);
    send_telemetry(16'd600, 5'd0);
    send_telemetry(16'd601, 5'd0);
    send_telemetry(16'd750, 5'd0);
    send_telemetry(16'd751, 5'd0);
    send_telemetry(16'd939, 5'(-16));
    send_telemetry(16'd940, 5'(-16));
    send_telemetry(16'd815, 5'd15);
    send_telemetry(16'd816, 5'd15);
    send_telemetry(16'd875, 5'd0);
    send_telemetry(16'd876, 5'd0);
    send_telemetry(16'd843, 5'd8);
    send_telemetry(16'd844, 5'd8);
    send_telemetry(16'd879, 5'(-1));

    while (useful < RANDOM_ITEMS) begin
      send_random_item(counted);
      if (counted) useful++;
      // Halfway through, let the pipeline run completely dry once.
      if (useful == RANDOM_ITEMS / 2 && counted) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("rev_light_bar_color_and_fill_tb passed");
    end else begin
      $display("rev_light_bar_color_and_fill_tb failed");
    end
    $finish;
  end

endmodule
